// ===== hw/rtl/fcc_neighbour_enumerator_defines.svh =====
// Assertion macros used by the neighbour enumerator emit stage.
`ifndef FCC_NEIGHBOUR_ENUMERATOR_DEFINES_SVH
`define FCC_NEIGHBOUR_ENUMERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcc neighbour enumerator: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcc neighbour enumerator: next-cycle check failed");

`endif

// ===== hw/rtl/fcc_nbr_pkg.sv =====
// Types, constants and the neighbour offset tables of the FCC neighbour enumerator.
package fcc_nbr_pkg;

  localparam int MAX_DIM = 1024;
  localparam int CFG_W   = 11;
  localparam int CRD_W   = 10;
  localparam int EXT_W   = 12;
  localparam int NB_NEAR = 12;
  localparam int NB_ALL  = 18;
  localparam int POS_W   = 5;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] CFG_NUM_ROWS    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_NUM_COLUMNS = 2'd1;
  localparam logic [IDX_W-1:0] CFG_NUM_LAYERS  = 2'd2;

  typedef enum logic [1:0] {
    ST_GIVEN = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] layers;
  } dims_t;

  typedef struct packed {
    status_t           status;
    logic [CRD_W-1:0]  row;
    logic [CRD_W-1:0]  col;
    logic [CRD_W-1:0]  layer;
    logic              odd;
    logic [NB_ALL-1:0] mask;
  } item_t;

  typedef struct packed {
    logic [EXT_W-1:0] r;
    logic [EXT_W-1:0] c;
    logic [EXT_W-1:0] l;
  } coord_t;

  // Row, column (aligned point) and layer offsets by position.
  localparam logic signed [2:0] NB_DR [NB_ALL] = '{
    -3'sd1, -3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd1,
    3'sd1, 3'sd1, 3'sd1, -3'sd2, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd2};
  localparam logic signed [2:0] NB_DC [NB_ALL] = '{
    3'sd0, -3'sd1, 3'sd0, 3'sd0, -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd0,
    -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0, -3'sd1, 3'sd0, 3'sd1, 3'sd0};
  localparam logic signed [2:0] NB_DL [NB_ALL] = '{
    -3'sd1, 3'sd0, 3'sd1, 3'sd0, -3'sd1, 3'sd1, 3'sd1, -3'sd1, -3'sd1,
    3'sd0, 3'sd1, 3'sd0, 3'sd0, -3'sd2, 3'sd0, 3'sd2, 3'sd0, 3'sd0};
  // Bit p set: for odd centres (row plus layer odd) the column of position p moves one to the right.
  localparam logic [NB_ALL-1:0] NB_SHIFT = 18'b000000101011111010;

  function automatic logic [EXT_W-1:0] ext_delta(input logic signed [2:0] d);
    return {{(EXT_W-3){d[2]}}, d};
  endfunction

  // Neighbour coordinates in 12-bit two's complement; negatives read as huge.
  function automatic coord_t nb_coord(input logic [POS_W-1:0] pos,
                                      input logic [CRD_W-1:0] row,
                                      input logic [CRD_W-1:0] col,
                                      input logic [CRD_W-1:0] layer,
                                      input logic             odd);
    coord_t co;
    co.r = EXT_W'(row) + ext_delta(NB_DR[pos]);
    co.c = EXT_W'(col) + ext_delta(NB_DC[pos]) + EXT_W'(odd & NB_SHIFT[pos]);
    co.l = EXT_W'(layer) + ext_delta(NB_DL[pos]);
    return co;
  endfunction

endpackage

// ===== hw/rtl/fcc_nbr_eval.sv =====
// Classifies an incoming centre point and builds its mask of neighbours inside the lattice.
module fcc_nbr_eval
  import fcc_nbr_pkg::*;
(
  input  logic             func,
  input  logic [CRD_W-1:0] row,
  input  logic [CRD_W-1:0] col,
  input  logic [CRD_W-1:0] layer,
  input  dims_t            dims,
  output item_t            item
);

  logic              odd;
  logic              centre_in;
  logic [NB_ALL-1:0] mask;
  coord_t            co [NB_ALL];

  assign odd = row[0] ^ layer[0];
  assign centre_in = ({1'b0, row} < dims.rows) && ({1'b0, col} < dims.cols) &&
                     ({1'b0, layer} < dims.layers);

  // A negative coordinate wraps to a value above any size, so one compare per axis.
  always_comb begin
    for (int i = 0; i < NB_ALL; i++) begin
      co[i] = nb_coord(POS_W'(i), row, col, layer, odd);
      mask[i] = (co[i].r < EXT_W'(dims.rows)) && (co[i].c < EXT_W'(dims.cols)) &&
                (co[i].l < EXT_W'(dims.layers)) && (func || i < NB_NEAR);
    end
  end

  always_comb begin
    item.row   = row;
    item.col   = col;
    item.layer = layer;
    item.odd   = odd;
    if (!centre_in) begin
      item.status = ST_RANGE;
      item.mask   = '0;
    end else if (mask == '0) begin
      item.status = ST_NONE;
      item.mask   = '0;
    end else begin
      item.status = ST_GIVEN;
      item.mask   = mask;
    end
  end

endmodule

// ===== hw/rtl/fcc_nbr_emit.sv =====
// Holds the current centre point and sends its neighbours, one word per cycle unless the output stalls.
`include "fcc_neighbour_enumerator_defines.svh"
module fcc_nbr_emit
  import fcc_nbr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            item_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [POS_W-1:0] out_position,
  output logic [CRD_W-1:0] out_nb_row,
  output logic [CRD_W-1:0] out_nb_col,
  output logic [CRD_W-1:0] out_nb_layer,
  output logic             out_last
);

  logic              item_v_r, item_v_nxt;
  item_t             item_r, item_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [CRD_W-1:0]  out_row_r, out_row_nxt;
  logic [CRD_W-1:0]  out_col_r, out_col_nxt;
  logic [CRD_W-1:0]  out_layer_r, out_layer_nxt;
  logic              out_last_r, out_last_nxt;

  logic [POS_W-1:0]  sel_pos;
  logic [NB_ALL-1:0] rest;
  logic              last_now;
  logic              adv;
  logic              fire;
  logic              take;
  coord_t            sel_co;

  // Lowest remaining position goes out first.
  always_comb begin
    sel_pos = '0;
    for (int i = NB_ALL - 1; i >= 0; i--) begin
      if (item_r.mask[i]) begin
        sel_pos = POS_W'(i);
      end
    end
  end

  assign rest     = item_r.mask & ~(NB_ALL'(1) << sel_pos);
  assign last_now = (item_r.status != ST_GIVEN) || (rest == '0);
  assign adv      = !out_valid_r || out_ready;
  assign fire     = item_v_r && adv;
  assign in_ready = !item_v_r || (fire && last_now);
  assign take     = in_valid && in_ready;
  assign sel_co   = nb_coord(sel_pos, item_r.row, item_r.col, item_r.layer, item_r.odd);

  always_comb begin
    item_v_nxt = item_v_r;
    item_nxt   = item_r;
    if (take) begin
      item_v_nxt = 1'b1;
      item_nxt   = item_in;
    end else if (fire) begin
      item_v_nxt    = !last_now;
      item_nxt.mask = rest;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_layer_nxt  = out_layer_r;
    out_last_nxt   = out_last_r;
    if (fire) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = item_r.status;
      out_last_nxt   = last_now;
      if (item_r.status == ST_GIVEN) begin
        out_pos_nxt   = sel_pos;
        out_row_nxt   = sel_co.r[CRD_W-1:0];
        out_col_nxt   = sel_co.c[CRD_W-1:0];
        out_layer_nxt = sel_co.l[CRD_W-1:0];
      end else begin
        out_pos_nxt   = '0;
        out_row_nxt   = '0;
        out_col_nxt   = '0;
        out_layer_nxt = '0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      item_v_r    <= item_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r       <= item_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_layer_r  <= out_layer_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;
  assign out_nb_row   = out_row_r;
  assign out_nb_col   = out_col_r;
  assign out_nb_layer = out_layer_r;
  assign out_last     = out_last_r;

  `FCC_ASSERT_NOW(a_given_has_mask, clk, rst_n, item_v_r && item_r.status == ST_GIVEN, item_r.mask != '0)
  `FCC_ASSERT_NOW(a_special_no_mask, clk, rst_n, item_v_r && item_r.status != ST_GIVEN, item_r.mask == '0)
  `FCC_ASSERT_NEXT(a_item_stays, clk, rst_n, fire && !last_now, item_v_r)
  `FCC_ASSERT_NEXT(a_pos_rises, clk, rst_n, fire && !last_now, out_pos_r < sel_pos)

endmodule

// ===== hw/rtl/fcc_neighbour_enumerator.sv =====
// Top level of the FCC lattice neighbour enumerator: size registers and the two stages.
//
// For each centre point word the block sends, in position order, one word per
// neighbour inside the configured lattice (positions 0 to 11, plus 12 to 17 in
// 18-neighbourhood mode), with last set on the final one; an out-of-range centre
// gives a single status-2 word, and a centre with no neighbour inside a single
// status-1 word. One result word leaves per cycle unless out_ready stalls the
// output; a centre point holds the block until its last word goes, and the next
// centre point is taken in the cycle its predecessor's last word is loaded into
// the output register. The neighbour mask is built as the word is taken, and the
// output stage walks it lowest bit first. Size registers read 1 after reset and
// are limited to the lattice maximum as they are written.
module fcc_neighbour_enumerator
  import fcc_nbr_pkg::*;
#(
  parameter int LAT_MAX = MAX_DIM
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_func,
  input  logic [CRD_W-1:0] in_row,
  input  logic [CRD_W-1:0] in_col,
  input  logic [CRD_W-1:0] in_layer,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [POS_W-1:0] out_position,
  output logic [CRD_W-1:0] out_nb_row,
  output logic [CRD_W-1:0] out_nb_col,
  output logic [CRD_W-1:0] out_nb_layer,
  output logic             out_last
);

  // A size register holds at most 2047, so larger limits never clip.
  localparam int               DIM_LIM   = (LAT_MAX > 2047) ? 2047 : LAT_MAX;
  localparam logic [CFG_W-1:0] DIM_LIM_W = CFG_W'(DIM_LIM);

  dims_t            dims_r, dims_nxt;
  logic [CFG_W-1:0] wdata_lim;
  item_t            item_in;

  assign wdata_lim = (cfg_wdata > DIM_LIM_W) ? DIM_LIM_W : cfg_wdata;

  always_comb begin
    dims_nxt = dims_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ROWS:    dims_nxt.rows   = wdata_lim;
        CFG_NUM_COLUMNS: dims_nxt.cols   = wdata_lim;
        CFG_NUM_LAYERS:  dims_nxt.layers = wdata_lim;
        default:         dims_nxt = dims_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.rows   <= CFG_W'(1);
      dims_r.cols   <= CFG_W'(1);
      dims_r.layers <= CFG_W'(1);
    end else begin
      dims_r <= dims_nxt;
    end
  end

  fcc_nbr_eval u_eval (
    .func  (in_func),
    .row   (in_row),
    .col   (in_col),
    .layer (in_layer),
    .dims  (dims_r),
    .item  (item_in)
  );

  fcc_nbr_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .item_in      (item_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_position (out_position),
    .out_nb_row   (out_nb_row),
    .out_nb_col   (out_nb_col),
    .out_nb_layer (out_nb_layer),
    .out_last     (out_last)
  );

endmodule

// ===== tb/tb_fcc_neighbour_enumerator.sv =====
// Testbench for the FCC lattice neighbour enumerator: directed and random centre points.
module tb_fcc_neighbour_enumerator;
  timeunit 1ns;
  timeprecision 1ps;

  import fcc_nbr_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int SETTLE_CYCLES  = 6;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] col;
    logic [CRD_W-1:0] layer;
    logic             last;
  } nbr_word_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic             in_func;
  logic [CRD_W-1:0] in_row;
  logic [CRD_W-1:0] in_col;
  logic [CRD_W-1:0] in_layer;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       out_status;
  logic [POS_W-1:0] out_position;
  logic [CRD_W-1:0] out_nb_row;
  logic [CRD_W-1:0] out_nb_col;
  logic [CRD_W-1:0] out_nb_layer;
  logic             out_last;

  // Offsets by position; odd centres move the flagged columns one to the right.
  int row_step [NB_ALL] = '{-1, -1, -1, -1, 0, 0, 0, 0, 1, 1, 1, 1, -2, 0, 0, 0, 0, 2};
  int col_step [NB_ALL] = '{0, -1, 0, 0, -1, -1, 0, 0, 0, -1, 0, 0, 0, 0, -1, 0, 1, 0};
  int lay_step [NB_ALL] = '{-1, 0, 1, 0, -1, 1, 1, -1, -1, 0, 1, 0, 0, -2, 0, 2, 0, 0};
  bit odd_shift [NB_ALL] = '{0, 1, 0, 1, 1, 1, 1, 1, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0};

  logic [CFG_W-1:0] lat_rows;
  logic [CFG_W-1:0] lat_cols;
  logic [CFG_W-1:0] lat_layers;

  nbr_word_t expected_words[$];
  int        fail_count;
  int        words_checked;
  int        points_sent;
  int        size_settings;
  int        cycle_count;
  bit        tx_idle;
  bit        rx_idle;

  fcc_neighbour_enumerator DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_layer     (in_layer),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_position (out_position),
    .out_nb_row   (out_nb_row),
    .out_nb_col   (out_nb_col),
    .out_nb_layer (out_nb_layer),
    .out_last     (out_last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
      $display("fcc_neighbour_enumerator verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !rx_idle || ($urandom_range(99) >= 35);
  end

  function automatic int clip_dim(input logic [CFG_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic bit in_lattice(input int r, input int c, input int l);
    return r >= 0 && r < clip_dim(lat_rows) && c >= 0 && c < clip_dim(lat_cols) &&
           l >= 0 && l < clip_dim(lat_layers);
  endfunction

  task automatic predict_neighbours(input logic func, input logic [CRD_W-1:0] row,
                                    input logic [CRD_W-1:0] col,
                                    input logic [CRD_W-1:0] layer);
    nbr_word_t words[$];
    nbr_word_t w;
    int        span;
    int        nr;
    int        nc;
    int        nl;
    bit        odd;
    span = func ? NB_ALL : NB_NEAR;
    odd  = (int'(row) + int'(layer)) % 2;
    w    = '0;
    if (!in_lattice(row, col, layer)) begin
      w.status = ST_RANGE;
      words = {words, w};
    end else begin
      for (int p = 0; p < span; p++) begin
        nr = int'(row) + row_step[p];
        nc = int'(col) + col_step[p] + ((odd && odd_shift[p]) ? 1 : 0);
        nl = int'(layer) + lay_step[p];
        if (in_lattice(nr, nc, nl)) begin
          w.status   = ST_GIVEN;
          w.position = POS_W'(p);
          w.row      = CRD_W'(nr);
          w.col      = CRD_W'(nc);
          w.layer    = CRD_W'(nl);
          words = {words, w};
        end
      end
      if (words.size() == 0) begin
        w        = '0;
        w.status = ST_NONE;
        words = {words, w};
      end
    end
    words[words.size() - 1].last = 1'b1;
    foreach (words[i]) expected_words = {expected_words, words[i]};
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    nbr_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result word, expected none, actual status %0d position %0d",
                 $time, out_status, out_position);
      end else begin
        want = expected_words.pop_front();
        check_field("status", want.status, out_status);
        check_field("position", want.position, out_position);
        check_field("nb_row", want.row, out_nb_row);
        check_field("nb_col", want.col, out_nb_col);
        check_field("nb_layer", want.layer, out_nb_layer);
        check_field("last", want.last, out_last);
        words_checked++;
      end
    end
  end

  // Valid stays high between back-to-back words; only a gap lowers it.
  task automatic send_point(input logic func, input int row, input int col, input int layer);
    while (tx_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_row   <= CRD_W'(row);
    in_col   <= CRD_W'(col);
    in_layer <= CRD_W'(layer);
    do @(posedge clk); while (!in_ready);
    predict_neighbours(func, CRD_W'(row), CRD_W'(col), CRD_W'(layer));
    points_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    case (idx)
      CFG_NUM_ROWS:    lat_rows   = CFG_W'(value);
      CFG_NUM_COLUMNS: lat_cols   = CFG_W'(value);
      CFG_NUM_LAYERS:  lat_layers = CFG_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_lattice(input int rows, input int cols, input int layers);
    drain_results();
    write_reg(CFG_NUM_ROWS, rows);
    write_reg(CFG_NUM_COLUMNS, cols);
    write_reg(CFG_NUM_LAYERS, layers);
    cfg_we <= 1'b0;
    size_settings++;
  endtask

  // Mostly inside, often on an edge, sometimes one past it or anywhere in the field.
  function automatic int pick_coord(input int limit);
    case ($urandom_range(9))
      0: return $urandom_range(0, 1023);
      1: return (limit > 1023) ? 1023 : limit;
      2: return 0;
      3: return limit - 1;
      default: return $urandom_range(0, limit - 1);
    endcase
  endfunction

  task automatic run_points(input int count);
    for (int i = 0; i < count; i++) begin
      send_point($urandom_range(1), pick_coord(clip_dim(lat_rows)),
                 pick_coord(clip_dim(lat_cols)), pick_coord(clip_dim(lat_layers)));
    end
  endtask

  task automatic test_reset_size();
    send_point(1'b0, 0, 0, 0);
    send_point(1'b1, 0, 0, 0);
    send_point(1'b0, 0, 1, 0);
    send_point(1'b1, 0, 0, 1);
  endtask

  task automatic test_zero_size();
    set_lattice(0, 1, 1);
    send_point(1'b1, 0, 0, 0);
    set_lattice(1, 0, 1);
    send_point(1'b0, 0, 0, 0);
    set_lattice(1, 1, 0);
    send_point(1'b1, 0, 0, 0);
  endtask

  task automatic test_small_lattice();
    set_lattice(5, 5, 5);
    send_point(1'b1, 2, 2, 2);
    send_point(1'b1, 2, 2, 1);
    send_point(1'b0, 0, 0, 0);
    send_point(1'b1, 0, 0, 0);
    send_point(1'b1, 4, 4, 4);
    send_point(1'b0, 4, 4, 3);
    send_point(1'b1, 1, 2, 2);
    send_point(1'b0, 5, 0, 0);
  endtask

  task automatic test_size_extremes();
    set_lattice(2047, 1024, 2047);
    send_point(1'b1, 1023, 1023, 1023);
    send_point(1'b1, 0, 0, 0);
    send_point(1'b0, 1023, 0, 1022);
    send_point(1'b1, 512, 511, 510);
    set_lattice(1023, 1024, 1);
    send_point(1'b0, 1023, 5, 0);
    send_point(1'b1, 1022, 1023, 0);
  endtask

  task automatic test_random_small_lattices();
    for (int phase = 0; phase < 5; phase++) begin
      set_lattice($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6));
      run_points(16);
    end
  endtask

  task automatic test_random_large_lattices();
    set_lattice(1024, 2047, 1024);
    run_points(20);
    set_lattice($urandom_range(1, 2047), $urandom_range(1, 2047), $urandom_range(1, 2047));
    run_points(20);
  endtask

  task automatic test_back_to_back();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_lattice($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(2, 8));
    run_points(30);
    drain_results();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_NUM_ROWS;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_func     <= 1'b0;
    in_row      <= '0;
    in_col      <= '0;
    in_layer    <= '0;
    out_ready   <= 1'b0;
    lat_rows    = 1;
    lat_cols    = 1;
    lat_layers  = 1;
    fail_count  = 0;
    words_checked = 0;
    points_sent = 0;
    size_settings = 1;
    cycle_count = 0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_size();
    test_zero_size();
    test_small_lattice();
    test_size_extremes();
    test_random_small_lattices();
    test_random_large_lattices();
    test_back_to_back();

    drain_results();
    repeat (16) @(posedge clk);
    $display("Sent %0d centre points over %0d lattice sizes, checked %0d neighbour words.",
             points_sent, size_settings, words_checked);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("fcc_neighbour_enumerator verification clean");
    end else begin
      $display("%0d mismatches, %0d words never seen", fail_count, expected_words.size());
      $display("fcc_neighbour_enumerator verification failed");
    end
    $finish;
  end

endmodule
